@@ design/rps_pkg.sv @@
// rps_pkg: shared constants, types and small functions for the relative
// position to spherical converter. No dependencies.
`timescale 1ns / 1ps

package rps_pkg;

  // CORDIC datapath: scaled vectors stay below 2^55 before gain growth
  localparam int CORD_W     = 60;
  localparam int SCALE_BITS = 55;

  // angle accumulator, degrees Q20
  localparam int ANG_W = 32;

  // result angle fields, degrees Q8
  localparam int BEAR_W = 17;
  localparam int ELEV_W = 16;

  localparam logic signed [ANG_W-1:0] HALF_TURN_Q20 = 32'sd188743680;
  localparam logic signed [ANG_W-1:0] BEAR_LIMIT    = 32'sd46080;
  localparam logic signed [ANG_W-1:0] ELEV_LIMIT    = 32'sd23040;
  localparam logic signed [ANG_W-1:0] ROUND_BIAS    = 32'sd2048;
  localparam int                      ROUND_SHIFT   = 12;

  // horizontal length correction: drop 16 bits, multiply by round(2^16/K)
  localparam int                    GAIN_SHIFT   = 16;
  localparam int                    INV_GAIN_W   = 16;
  localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q16 = 16'd39797;

  typedef struct packed {
    logic hz;   // dx and dy both zero
    logic az;   // whole difference vector zero
  } rps_flags_t;

  // round(atan(2^-i) * 180/pi * 2^20)
  function automatic logic signed [ANG_W-1:0] atan_q20(input logic [4:0] idx);
    case (idx) inside
      5'd0:  atan_q20 = 32'sd47185920;
      5'd1:  atan_q20 = 32'sd27855475;
      5'd2:  atan_q20 = 32'sd14718068;
      5'd3:  atan_q20 = 32'sd7471121;
      5'd4:  atan_q20 = 32'sd3750059;
      5'd5:  atan_q20 = 32'sd1876857;
      5'd6:  atan_q20 = 32'sd938658;
      5'd7:  atan_q20 = 32'sd469357;
      5'd8:  atan_q20 = 32'sd234682;
      5'd9:  atan_q20 = 32'sd117342;
      5'd10: atan_q20 = 32'sd58671;
      5'd11: atan_q20 = 32'sd29335;
      5'd12: atan_q20 = 32'sd14668;
      5'd13: atan_q20 = 32'sd7334;
      5'd14: atan_q20 = 32'sd3667;
      5'd15: atan_q20 = 32'sd1833;
      5'd16: atan_q20 = 32'sd917;
      5'd17: atan_q20 = 32'sd458;
      5'd18: atan_q20 = 32'sd229;
      5'd19: atan_q20 = 32'sd115;
      5'd20: atan_q20 = 32'sd57;
      5'd21: atan_q20 = 32'sd29;
      5'd22: atan_q20 = 32'sd14;
      5'd23: atan_q20 = 32'sd7;
      5'd24: atan_q20 = 32'sd4;
      5'd25: atan_q20 = 32'sd2;
      5'd26: atan_q20 = 32'sd1;
      [5'd27:5'd31]: atan_q20 = '0;
    endcase
  endfunction

  // Q20 degrees to Q8 with round half up, then clamp to +/-lim
  function automatic logic signed [ANG_W-1:0] round_clamp(
      input logic signed [ANG_W-1:0] ang,
      input logic signed [ANG_W-1:0] lim);
    logic signed [ANG_W:0] biased;
    logic signed [ANG_W:0] q;
    logic signed [ANG_W:0] lim_x;
    biased = {ang[ANG_W-1], ang} + {ROUND_BIAS[ANG_W-1], ROUND_BIAS};
    q      = biased >>> ROUND_SHIFT;
    lim_x  = {lim[ANG_W-1], lim};
    if (q > lim_x) begin
      q = lim_x;
    end else if (q < -lim_x) begin
      q = -lim_x;
    end
    return q[ANG_W-1:0];
  endfunction

endpackage

@@ design/rps_isqrt.sv @@
// rps_isqrt: pipelined integer square root, one root bit per stage, then a
// round-to-nearest stage. Depends on rps_pkg (file convention only).
`timescale 1ns / 1ps

module rps_isqrt #(
  parameter int SUM_W = 50,
  parameter int SB_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [SUM_W-1:0]     rad_i,
  input  logic [SB_W-1:0]      sb_i,
  output logic                 out_vld,
  output logic [SUM_W/2:0]     root_o,
  output logic [SB_W-1:0]      sb_o
);
  import rps_pkg::*;

  localparam int STEPS = SUM_W / 2;
  localparam int RW    = STEPS + 3;

  logic [RW-1:0]     rem_r  [STEPS];
  logic [STEPS-1:0]  root_r [STEPS];
  logic [SUM_W-1:0]  rad_r  [STEPS-1];
  logic [SB_W-1:0]   sb_r   [STEPS];
  logic              vld_r  [STEPS];

  logic [STEPS:0]    round_r;
  logic [SB_W-1:0]   sb_out_r;
  logic              vld_out_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RW-1:0]    cur_rem;
    logic [STEPS-1:0] cur_root;
    logic [SUM_W-1:0] cur_rad;
    logic [SB_W-1:0]  cur_sb;
    logic             cur_vld;
    logic [RW-1:0]    rem_sh;
    logic [RW-1:0]    trial;
    logic             ge;
    logic [RW-1:0]    rem_nxt;
    logic [STEPS-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = rad_i;
      assign cur_sb   = sb_i;
      assign cur_vld  = in_vld;
    end else begin : g_next
      assign cur_rem  = rem_r[k-1];
      assign cur_root = root_r[k-1];
      assign cur_rad  = rad_r[k-1];
      assign cur_sb   = sb_r[k-1];
      assign cur_vld  = vld_r[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh   = {cur_rem[RW-3:0], cur_rad[SUM_W-1 -: 2]};
    assign trial    = {1'b0, cur_root, 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {cur_root[STEPS-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= cur_sb;
      end
    end

    if (k < STEPS - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= {cur_rad[SUM_W-3:0], 2'b00};
        end
      end
    end
  end

  // remainder above the root means the value sits past root + 1/2
  logic             round_up;
  logic [STEPS:0]   round_nxt;

  assign round_up  = (rem_r[STEPS-1] > RW'(root_r[STEPS-1]));
  assign round_nxt = {1'b0, root_r[STEPS-1]} + (STEPS+1)'(round_up);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= vld_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      round_r  <= round_nxt;
      sb_out_r <= sb_r[STEPS-1];
    end
  end

  assign out_vld = vld_out_r;
  assign root_o  = round_r;
  assign sb_o    = sb_out_r;

endmodule

@@ design/rps_cordic.sv @@
// rps_cordic: unrolled CORDIC vectoring pipeline, one micro-rotation per
// register stage. Depends on rps_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module rps_cordic #(
  parameter int STAGES = 20,
  parameter int SB_W   = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [rps_pkg::CORD_W-1:0]  x_i,
  input  logic signed [rps_pkg::CORD_W-1:0]  y_i,
  input  logic signed [rps_pkg::ANG_W-1:0]   z_i,
  input  logic [SB_W-1:0]                    sb_i,
  output logic                               out_vld,
  output logic signed [rps_pkg::CORD_W-1:0]  x_o,
  output logic signed [rps_pkg::ANG_W-1:0]   z_o,
  output logic [SB_W-1:0]                    sb_o
);
  import rps_pkg::*;

  logic signed [CORD_W-1:0] x_r   [STAGES];
  logic signed [CORD_W-1:0] y_r   [STAGES-1];
  logic signed [ANG_W-1:0]  z_r   [STAGES];
  logic [SB_W-1:0]          sb_r  [STAGES];
  logic                     vld_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CORD_W-1:0] cur_x;
    logic signed [CORD_W-1:0] cur_y;
    logic signed [ANG_W-1:0]  cur_z;
    logic [SB_W-1:0]          cur_sb;
    logic                     cur_vld;
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    logic                     rot_cw;
    logic signed [ANG_W-1:0]  step_ang;

    if (i == 0) begin : g_first
      assign cur_x   = x_i;
      assign cur_y   = y_i;
      assign cur_z   = z_i;
      assign cur_sb  = sb_i;
      assign cur_vld = in_vld;
    end else begin : g_next
      assign cur_x   = x_r[i-1];
      assign cur_y   = y_r[i-1];
      assign cur_z   = z_r[i-1];
      assign cur_sb  = sb_r[i-1];
      assign cur_vld = vld_r[i-1];
    end

    assign xs       = cur_x >>> i;
    assign ys       = cur_y >>> i;
    assign rot_cw   = !cur_y[CORD_W-1];
    assign step_ang = atan_q20(5'(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]  <= rot_cw ? (cur_x + ys) : (cur_x - ys);
        z_r[i]  <= rot_cw ? (cur_z + step_ang) : (cur_z - step_ang);
        sb_r[i] <= cur_sb;
      end
    end

    // the last stage only needs x and the angle
    if (i < STAGES - 1) begin : g_y
      always_ff @(posedge clk) begin
        if (en) begin
          y_r[i] <= rot_cw ? (cur_y - xs) : (cur_y + xs);
        end
      end
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign x_o     = x_r[STAGES-1];
  assign z_o     = z_r[STAGES-1];
  assign sb_o    = sb_r[STAGES-1];

endmodule

@@ design/rps_gain.sv @@
// rps_gain: removes the CORDIC gain from the horizontal length,
// (x >>> 16) * round(2^16/K), as two half-width products over two stages.
// Depends on rps_pkg for widths and the gain constant.
`timescale 1ns / 1ps

module rps_gain #(
  parameter int SB_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [rps_pkg::CORD_W-1:0]  xf_i,
  input  logic [SB_W-1:0]                    sb_i,
  output logic                               out_vld,
  output logic signed [rps_pkg::CORD_W-1:0]  hs_o,
  output logic [SB_W-1:0]                    sb_o
);
  import rps_pkg::*;

  localparam int A_W  = CORD_W - GAIN_SHIFT;
  localparam int LO_W = A_W / 2;
  localparam int HI_W = A_W - LO_W;
  localparam int PL_W = LO_W + INV_GAIN_W;
  localparam int PH_W = HI_W + INV_GAIN_W + 1;

  logic [LO_W-1:0]          lo;
  logic signed [HI_W-1:0]   hi;
  logic [PL_W-1:0]          pl_nxt;
  logic signed [PH_W-1:0]   ph_nxt;
  logic [PL_W-1:0]          pl_r;
  logic signed [PH_W-1:0]   ph_r;
  logic [SB_W-1:0]          sb1_r;
  logic                     vld1_r;
  logic signed [CORD_W-1:0] hs_nxt;
  logic signed [CORD_W-1:0] hs_r;
  logic [SB_W-1:0]          sb2_r;
  logic                     vld2_r;

  // top bits of x are the floor shift by GAIN_SHIFT
  assign lo     = xf_i[GAIN_SHIFT +: LO_W];
  assign hi     = xf_i[CORD_W-1 -: HI_W];
  assign pl_nxt = lo * INV_GAIN_Q16;
  assign ph_nxt = hi * $signed({1'b0, INV_GAIN_Q16});

  assign hs_nxt = ({{(CORD_W-PH_W){ph_r[PH_W-1]}}, ph_r} <<< LO_W)
                + {{(CORD_W-PL_W){1'b0}}, pl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r  <= pl_nxt;
      ph_r  <= ph_nxt;
      sb1_r <= sb_i;
      hs_r  <= hs_nxt;
      sb2_r <= sb1_r;
    end
  end

  assign out_vld = vld2_r;
  assign hs_o    = hs_r;
  assign sb_o    = sb2_r;

endmodule

@@ design/relative_position_to_spherical_top.sv @@
// relative_position_to_spherical_top: difference vector to bearing, range and
// elevation. Uses rps_pkg, rps_isqrt, rps_cordic and rps_gain.
`timescale 1ns / 1ps

// Takes a target position and the own position (signed, same fixed-point
// format) and returns bearing atan2(dy,dx) and elevation in degrees Q8 plus
// the range |target - own| rounded to the nearest position LSB. The block is
// a fully pipelined, stateless datapath: one transaction is accepted every
// cycle while the output is not stalled, and each produces exactly one result
// transaction. The sum of squares is min(2*POSITION_WIDTH + 2, 64) bits wide.
// The square-root pipeline (one root bit per stage) runs ahead of the two
// CORDIC vectoring pipelines (bearing, then elevation), which take one
// micro-rotation per stage. While a result waits with out_tready low the
// whole pipe holds, and in_tready drops with it. A zero vector returns all
// zeros; with no horizontal offset the bearing is zero.

module relative_position_to_spherical_top #(
  parameter int POSITION_WIDTH = 24,
  parameter int CORDIC_STAGES  = 20
) (
  input  logic clk,
  input  logic rst_n,

  // input transaction
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata, low to high: target_x, target_y, target_z, own_x, own_y, own_z
  // (POSITION_WIDTH bits each, signed), zero padding to a byte boundary
  input  logic [((6*POSITION_WIDTH+7)/8)*8-1:0]  in_tdata,

  // result transaction
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tdata, low to high: bearing_deg (17, signed), range_len
  // (POSITION_WIDTH+1, unsigned), elevation_deg (16, signed), zero padding
  output logic [((rps_pkg::BEAR_W+POSITION_WIDTH+1+rps_pkg::ELEV_W+7)/8)*8-1:0]
                                                 out_tdata
);
  import rps_pkg::*;

  localparam int PW         = POSITION_WIDTH;
  localparam int DW         = PW + 1;                 // difference width
  localparam int RANGE_W    = PW + 1;
  localparam int SQ_W       = 2 * PW;                 // |d|^2 < 2^(2*PW)
  localparam int SUM_FULL   = 2 * PW + 2;
  localparam int SUM_W      = (SUM_FULL > 64) ? 64 : SUM_FULL;
  localparam int ROOT_W     = SUM_W / 2 + 1;
  localparam int PRE_SHIFT  = SCALE_BITS - PW;
  localparam int OUT_FLD_W  = BEAR_W + RANGE_W + ELEV_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // sideband carried alongside each pipeline
  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } sqrt_sb_t;

  typedef struct packed {
    logic [RANGE_W-1:0]   range;
    logic signed [DW-1:0] dz;
    rps_flags_t           flags;
  } brg_sb_t;

  typedef struct packed {
    logic [RANGE_W-1:0]       range;
    logic signed [DW-1:0]     dz;
    rps_flags_t               flags;
    logic signed [BEAR_W-1:0] bearing;
  } gain_sb_t;

  typedef struct packed {
    logic [RANGE_W-1:0]       range;
    rps_flags_t               flags;
    logic signed [BEAR_W-1:0] bearing;
  } elev_sb_t;

  // ---------------------------------------------------------------------
  // Flow control: every stage moves together. Bubbles travel as cleared
  // valid bits; a stalled output freezes the whole pipe.
  // ---------------------------------------------------------------------
  logic adv;
  logic out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  assign adv       = out_tready || !out_tvalid_r;
  assign in_tready = adv;

  // ---------------------------------------------------------------------
  // Stage A: difference vector (exact, one bit wider than a position)
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] tgt_x, tgt_y, tgt_z, own_x, own_y, own_z;
  logic signed [DW-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [DW-1:0] dx_a_r, dy_a_r, dz_a_r;
  logic                 vld_a_r;

  assign tgt_x = in_tdata[0*PW +: PW];
  assign tgt_y = in_tdata[1*PW +: PW];
  assign tgt_z = in_tdata[2*PW +: PW];
  assign own_x = in_tdata[3*PW +: PW];
  assign own_y = in_tdata[4*PW +: PW];
  assign own_z = in_tdata[5*PW +: PW];

  assign dx_nxt = {tgt_x[PW-1], tgt_x} - {own_x[PW-1], own_x};
  assign dy_nxt = {tgt_y[PW-1], tgt_y} - {own_y[PW-1], own_y};
  assign dz_nxt = {tgt_z[PW-1], tgt_z} - {own_z[PW-1], own_z};

  // ---------------------------------------------------------------------
  // Stage B: squares. Stage C: sum of squares (wraps at 64 bits)
  // ---------------------------------------------------------------------
  logic signed [2*DW-1:0] sqx_full, sqy_full, sqz_full;
  logic [SQ_W-1:0]        sqx_b_r, sqy_b_r, sqz_b_r;
  logic signed [DW-1:0]   dx_b_r, dy_b_r, dz_b_r;
  logic                   vld_b_r;

  assign sqx_full = dx_a_r * dx_a_r;
  assign sqy_full = dy_a_r * dy_a_r;
  assign sqz_full = dz_a_r * dz_a_r;

  logic [SUM_FULL-1:0] sum_full;
  logic [SUM_W-1:0]    sum_c_r;
  sqrt_sb_t            sb_c_r;
  logic                vld_c_r;

  assign sum_full = SUM_FULL'(sqx_b_r) + SUM_FULL'(sqy_b_r) + SUM_FULL'(sqz_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_tvalid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_a_r    <= dx_nxt;
      dy_a_r    <= dy_nxt;
      dz_a_r    <= dz_nxt;
      sqx_b_r   <= sqx_full[SQ_W-1:0];
      sqy_b_r   <= sqy_full[SQ_W-1:0];
      sqz_b_r   <= sqz_full[SQ_W-1:0];
      dx_b_r    <= dx_a_r;
      dy_b_r    <= dy_a_r;
      dz_b_r    <= dz_a_r;
      sum_c_r   <= sum_full[SUM_W-1:0];
      sb_c_r.dx <= dx_b_r;
      sb_c_r.dy <= dy_b_r;
      sb_c_r.dz <= dz_b_r;
    end
  end

  // ---------------------------------------------------------------------
  // Range: rounded integer square root, SUM_W/2 + 1 stages
  // ---------------------------------------------------------------------
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sqrt_sb_t          sq_sb;
  logic [$bits(sqrt_sb_t)-1:0] sq_sb_in;

  assign sq_sb_in = sb_c_r;

  rps_isqrt #(
    .SUM_W (SUM_W),
    .SB_W  ($bits(sqrt_sb_t))
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (vld_c_r),
    .rad_i   (sum_c_r),
    .sb_i    (sq_sb_in),
    .out_vld (sq_vld),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // ---------------------------------------------------------------------
  // Stage D: scale to the CORDIC format and fold the left half-plane onto
  // the right one; a folded vector's angle then starts at +/-180 degrees, else at 0.
  // ---------------------------------------------------------------------
  logic signed [CORD_W-1:0] sx, sy;
  logic                     neg_x;
  rps_flags_t               flags_nxt;
  logic signed [CORD_W-1:0] x0_nxt, y0_nxt;
  logic signed [ANG_W-1:0]  z0_nxt;

  assign sx    = {{(CORD_W-DW){sq_sb.dx[DW-1]}}, sq_sb.dx} <<< PRE_SHIFT;
  assign sy    = {{(CORD_W-DW){sq_sb.dy[DW-1]}}, sq_sb.dy} <<< PRE_SHIFT;
  assign neg_x = sq_sb.dx[DW-1];

  assign flags_nxt.hz = (sq_sb.dx == '0) && (sq_sb.dy == '0);
  assign flags_nxt.az = flags_nxt.hz && (sq_sb.dz == '0);

  always_comb begin
    x0_nxt = sx;
    y0_nxt = sy;
    z0_nxt = '0;
    if (neg_x) begin
      x0_nxt = -sx;
      y0_nxt = -sy;
      z0_nxt = sq_sb.dy[DW-1] ? -HALF_TURN_Q20 : HALF_TURN_Q20;
    end
  end

  logic signed [CORD_W-1:0] x0_d_r, y0_d_r;
  logic signed [ANG_W-1:0]  z0_d_r;
  brg_sb_t                  sb_d_r;
  logic                     vld_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (adv) begin
      vld_d_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_d_r       <= x0_nxt;
      y0_d_r       <= y0_nxt;
      z0_d_r       <= z0_nxt;
      sb_d_r.range <= sq_root[RANGE_W-1:0];
      sb_d_r.dz    <= sq_sb.dz;
      sb_d_r.flags <= flags_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Bearing CORDIC
  // ---------------------------------------------------------------------
  logic                     br_vld;
  logic signed [CORD_W-1:0] br_x;
  logic signed [ANG_W-1:0]  br_z;
  logic [$bits(brg_sb_t)-1:0] br_sb_in, br_sb_out;
  brg_sb_t                  br_sb;

  assign br_sb_in = sb_d_r;
  assign br_sb    = br_sb_out;

  rps_cordic #(
    .STAGES (CORDIC_STAGES),
    .SB_W   ($bits(brg_sb_t))
  ) u_cordic_brg (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (vld_d_r),
    .x_i     (x0_d_r),
    .y_i     (y0_d_r),
    .z_i     (z0_d_r),
    .sb_i    (br_sb_in),
    .out_vld (br_vld),
    .x_o     (br_x),
    .z_o     (br_z),
    .sb_o    (br_sb_out)
  );

  // ---------------------------------------------------------------------
  // Horizontal length without CORDIC gain; bearing rounded on the way.
  // With no horizontal offset both the bearing and the length are zero.
  // ---------------------------------------------------------------------
  logic signed [CORD_W-1:0] gn_x_in;
  logic signed [ANG_W-1:0]  brg_q8;
  gain_sb_t                 gn_sb_nxt;
  logic [$bits(gain_sb_t)-1:0] gn_sb_in, gn_sb_out;
  gain_sb_t                 gn_sb;
  logic                     gn_vld;
  logic signed [CORD_W-1:0] gn_hs;

  assign gn_x_in = br_sb.flags.hz ? '0 : br_x;
  assign brg_q8  = round_clamp(br_z, BEAR_LIMIT);

  assign gn_sb_nxt.range   = br_sb.range;
  assign gn_sb_nxt.dz      = br_sb.dz;
  assign gn_sb_nxt.flags   = br_sb.flags;
  assign gn_sb_nxt.bearing = br_sb.flags.hz ? '0 : brg_q8[BEAR_W-1:0];
  assign gn_sb_in          = gn_sb_nxt;
  assign gn_sb             = gn_sb_out;

  rps_gain #(
    .SB_W ($bits(gain_sb_t))
  ) u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (br_vld),
    .xf_i    (gn_x_in),
    .sb_i    (gn_sb_in),
    .out_vld (gn_vld),
    .hs_o    (gn_hs),
    .sb_o    (gn_sb_out)
  );

  // ---------------------------------------------------------------------
  // Elevation CORDIC on (horizontal length, scaled dz)
  // ---------------------------------------------------------------------
  logic signed [CORD_W-1:0] el_y_in;
  elev_sb_t                 el_sb_nxt;
  logic [$bits(elev_sb_t)-1:0] el_sb_in, el_sb_out;
  elev_sb_t                 el_sb;
  logic                     el_vld;
  logic signed [CORD_W-1:0] el_x;
  logic signed [ANG_W-1:0]  el_z;

  assign el_y_in = {{(CORD_W-DW){gn_sb.dz[DW-1]}}, gn_sb.dz} <<< PRE_SHIFT;

  assign el_sb_nxt.range   = gn_sb.range;
  assign el_sb_nxt.flags   = gn_sb.flags;
  assign el_sb_nxt.bearing = gn_sb.bearing;
  assign el_sb_in          = el_sb_nxt;
  assign el_sb             = el_sb_out;

  rps_cordic #(
    .STAGES (CORDIC_STAGES),
    .SB_W   ($bits(elev_sb_t))
  ) u_cordic_elev (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (gn_vld),
    .x_i     (gn_hs),
    .y_i     (el_y_in),
    .z_i     ('0),
    .sb_i    (el_sb_in),
    .out_vld (el_vld),
    .x_o     (el_x),
    .z_o     (el_z),
    .sb_o    (el_sb_out)
  );

  // only the sign of the final x of the elevation rotation is used: negative forces elevation to zero
  logic el_x_sign;
  assign el_x_sign = el_x[CORD_W-1];

  // ---------------------------------------------------------------------
  // Output register: elevation rounded; a zero vector or a negative final x forces it to zero
  // ---------------------------------------------------------------------
  logic signed [ANG_W-1:0]  elev_q8;
  logic signed [ELEV_W-1:0] elev_fld;
  logic [OUT_DATA_W-1:0]    out_tdata_nxt;

  assign elev_q8  = round_clamp(el_z, ELEV_LIMIT);
  assign elev_fld = (el_sb.flags.az || el_x_sign) ? '0 : elev_q8[ELEV_W-1:0];

  assign out_tdata_nxt = {{(OUT_DATA_W-OUT_FLD_W){1'b0}},
                          elev_fld, el_sb.range, el_sb.bearing};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= el_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ verif/testbench.sv @@
// testbench: self-checking bench for relative_position_to_spherical_top.
// Drives position-fix transactions, predicts bearing/range/elevation locally
// and checks every result transaction. Depends on rps_pkg and the top level.
`timescale 1ns / 1ps

module testbench;

  localparam int POS_W   = 24;
  localparam int STAGES  = 20;
  localparam int RNG_W   = POS_W + 1;
  localparam int BEAR_W  = rps_pkg::BEAR_W;
  localparam int ELEV_W  = rps_pkg::ELEV_W;
  localparam int IN_W    = ((6*POS_W+7)/8)*8;
  localparam int OUT_W   = ((BEAR_W+RNG_W+ELEV_W+7)/8)*8;

  localparam longint POS_MAX     = 64'sd8388607;
  localparam longint POS_MIN     = -64'sd8388608;
  localparam int     PRE_SHIFT   = 55 - POS_W;
  localparam longint HALF_TURN   = 64'sd180 * 64'sd1048576;  // 180 deg in Q20
  localparam longint INV_GAIN    = 64'sd39797;               // round(2^16/K)
  localparam longint BEAR_LIM_Q8 = 64'sd46080;
  localparam longint ELEV_LIM_Q8 = 64'sd23040;

  localparam int DRAIN_LIMIT = 20000;   // cycles allowed for the pipe to empty
  localparam int TAIL_CYCLES = 100;
  localparam longint TIMEOUT_NS = 64'd5000000;

  typedef logic signed [POS_W-1:0] coord_t;

  typedef struct {
    coord_t tx, ty, tz;
    coord_t ox, oy, oz;
  } pos_fix_t;

  typedef struct {
    logic signed [BEAR_W-1:0] bearing;
    logic        [RNG_W-1:0]  range_len;
    logic signed [ELEV_W-1:0] elev;
  } spherical_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  spherical_t pending_spherical[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fixes_sent = 0;
  int results_checked = 0;
  int error_count = 0;

  relative_position_to_spherical_top #(
    .POSITION_WIDTH(POS_W),
    .CORDIC_STAGES (STAGES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // atan(2^-i) in degrees, Q20
  function automatic longint atan_step_q20(input int i);
    case (i)
      0:  return 47185920;
      1:  return 27855475;
      2:  return 14718068;
      3:  return 7471121;
      4:  return 3750059;
      5:  return 1876857;
      6:  return 938658;
      7:  return 469357;
      8:  return 234682;
      9:  return 117342;
      10: return 58671;
      11: return 29335;
      12: return 14668;
      13: return 7334;
      14: return 3667;
      15: return 1833;
      16: return 917;
      17: return 458;
      18: return 229;
      19: return 115;
      20: return 57;
      21: return 29;
      22: return 14;
      23: return 7;
      24: return 4;
      25: return 2;
      26: return 1;
      default: return 0;
    endcase
  endfunction

  // vectoring mode: drives y to zero, accumulates the angle in z
  function automatic longint cordic_vectoring(input longint x_in, input longint y_in,
                                              input longint z_in, output longint x_out);
    longint x, y, z, xs, ys;
    x = x_in;
    y = y_in;
    z = z_in;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step_q20(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step_q20(i);
      end
    end
    x_out = x;
    return z;
  endfunction

  function automatic longint round_q8(input longint ang_q20, input longint lim);
    longint q;
    q = (ang_q20 + 64'sd2048) >>> 12;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  // nearest integer square root, digit-by-digit
  function automatic longint unsigned round_sqrt(input longint unsigned v);
    longint unsigned rem, root, b;
    rem  = v;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (v - root * root > root) root = root + 1;
    return root;
  endfunction

  function automatic spherical_t predict_spherical(input pos_fix_t f);
    spherical_t s;
    longint dx, dy, dz, x, y, z0, xf, horiz, bearing, elev;
    longint unsigned sum_sq;
    dx = longint'(f.tx) - longint'(f.ox);
    dy = longint'(f.ty) - longint'(f.oy);
    dz = longint'(f.tz) - longint'(f.oz);
    sum_sq  = longint'(dx * dx + dy * dy + dz * dz);
    bearing = 0;
    elev    = 0;
    horiz   = 0;
    if (dx != 0 || dy != 0) begin
      x  = dx * (64'sd1 <<< PRE_SHIFT);
      y  = dy * (64'sd1 <<< PRE_SHIFT);
      z0 = 0;
      // left half plane: rotate by a half turn first
      if (dx < 0) begin
        z0 = (dy >= 0) ? HALF_TURN : -HALF_TURN;
        x  = -x;
        y  = -y;
      end
      bearing = round_q8(cordic_vectoring(x, y, z0, xf), BEAR_LIM_Q8);
      horiz   = (xf >>> 16) * INV_GAIN;
    end
    if (dx != 0 || dy != 0 || dz != 0) begin
      elev = round_q8(cordic_vectoring(horiz, dz * (64'sd1 <<< PRE_SHIFT), 0, xf),
                      ELEV_LIM_Q8);
    end
    s.bearing   = bearing[BEAR_W-1:0];
    s.range_len = RNG_W'(round_sqrt(sum_sq));
    s.elev      = elev[ELEV_W-1:0];
    return s;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    spherical_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.bearing   = out_tdata[BEAR_W-1:0];
      got.range_len = out_tdata[BEAR_W +: RNG_W];
      got.elev      = out_tdata[BEAR_W+RNG_W +: ELEV_W];
      if (pending_spherical.size() == 0) begin
        $error("result with no fix pending: bearing %0d range %0d elevation %0d",
               got.bearing, got.range_len, got.elev);
        error_count++;
      end else begin
        want = pending_spherical.pop_front();
        if (got.bearing !== want.bearing) begin
          $error("bearing_deg: expected %0d, got %0d", want.bearing, got.bearing);
          error_count++;
        end
        if (got.range_len !== want.range_len) begin
          $error("range_len: expected %0d, got %0d", want.range_len, got.range_len);
          error_count++;
        end
        if (got.elev !== want.elev) begin
          $error("elevation_deg: expected %0d, got %0d", want.elev, got.elev);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_fix(input pos_fix_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f.oz, f.oy, f.ox, f.tz, f.ty, f.tx};
    do @(posedge clk); while (!in_tready);
    pending_spherical.insert(pending_spherical.size(), predict_spherical(f));
    fixes_sent++;
  endtask

  task automatic wait_results_drained();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (pending_spherical.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic set_flow(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic pos_fix_t make_fix(input int tx, input int ty, input int tz,
                                        input int ox, input int oy, input int oz);
    pos_fix_t f;
    f.tx = coord_t'(tx);
    f.ty = coord_t'(ty);
    f.tz = coord_t'(tz);
    f.ox = coord_t'(ox);
    f.oy = coord_t'(oy);
    f.oz = coord_t'(oz);
    return f;
  endfunction

  // random signed offset with a random bit length up to max_bits
  function automatic longint rand_delta(input int max_bits);
    int bits;
    longint mag;
    bits = $urandom_range(max_bits, 0);
    mag  = (bits == 0) ? 0 : longint'($urandom_range((1 << bits) - 1));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // own coordinate such that own + d stays inside the field
  function automatic coord_t pick_own(input longint d);
    longint lo, hi;
    lo = (POS_MIN - d > POS_MIN) ? POS_MIN - d : POS_MIN;
    hi = (POS_MAX - d < POS_MAX) ? POS_MAX - d : POS_MAX;
    return coord_t'(lo + longint'($urandom_range(int'(hi - lo))));
  endfunction

  task automatic send_offset(input longint dx, input longint dy, input longint dz);
    pos_fix_t f;
    f.ox = pick_own(dx);
    f.oy = pick_own(dy);
    f.oz = pick_own(dz);
    f.tx = coord_t'(longint'(f.ox) + dx);
    f.ty = coord_t'(longint'(f.oy) + dy);
    f.tz = coord_t'(longint'(f.oz) + dz);
    send_fix(f);
  endtask

  task automatic test_special_cases();
    send_fix(make_fix(1000, -2000, 300, 1000, -2000, 300));       // zero vector
    send_fix(make_fix(0, 0, 0, 0, 0, 0));
    send_fix(make_fix(8388607, 8388607, 8388607,
                      -8388608, -8388608, -8388608));           // largest range
    send_fix(make_fix(-8388608, -8388608, -8388608,
                      8388607, 8388607, 8388607));
    send_fix(make_fix(0, 0, 5000, 0, 0, 0));                     // straight up
    send_fix(make_fix(0, 0, -8388608, 0, 0, 8388607));           // straight down
    send_fix(make_fix(-256, 0, 0, 0, 0, 0));                     // negative x axis
    send_fix(make_fix(-8388608, 42, 7, 8388607, 42, 0));
    send_fix(make_fix(256, 0, 0, 0, 0, 0));
    send_fix(make_fix(0, 256, 0, 0, 0, 0));
    send_fix(make_fix(0, -256, 0, 0, 0, 0));
    send_fix(make_fix(-8388608, -1, 0, 8388607, 0, 0));          // just above -180
    send_fix(make_fix(-8388608, 1, 0, 8388607, 0, 0));           // just below +180
    send_fix(make_fix(1, 0, 0, 0, 0, 0));                        // one LSB
    send_fix(make_fix(0, 0, -1, 0, 0, 0));
    send_fix(make_fix(1, 1, 1, 0, 0, 0));
    send_fix(make_fix(-1, -1, 0, 0, 0, 0));
    send_fix(make_fix(4096, 4096, 5793, 0, 0, 0));               // about 45 deg up
    send_fix(make_fix(-4096, 4096, -4096, 0, 0, 0));
    send_fix(make_fix(1, 0, 8388607, 0, 0, -8388608));           // nearly vertical
    send_fix(make_fix(8388607, 0, 1, -8388608, 0, 0));           // nearly flat
    send_fix(make_fix(24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                      24'h555555, 24'hAAAAAA, 24'h555555));
  endtask

  task automatic test_full_scale(input int n);
    pos_fix_t f;
    repeat (n) begin
      f.tx = coord_t'($urandom);
      f.ty = coord_t'($urandom);
      f.tz = coord_t'($urandom);
      f.ox = coord_t'($urandom);
      f.oy = coord_t'($urandom);
      f.oz = coord_t'($urandom);
      send_fix(f);
    end
  endtask

  // targets at random offsets of up to 24 bits: short vectors exercise precision
  task automatic test_near_targets(input int n);
    repeat (n) send_offset(rand_delta(24), rand_delta(24), rand_delta(24));
  endtask

  task automatic test_axis_targets(input int n);
    longint m, z;
    repeat (n) begin
      m = rand_delta(24);
      z = rand_delta(24);
      case ($urandom_range(7))
        0: send_offset(m, 0, 0);
        1: send_offset(0, m, 0);
        2: send_offset(0, 0, m);
        3: send_offset(-1 - longint'($urandom_range(16777214)), 0, z);
        4: send_offset(m, $urandom_range(1) ? m : -m, z);
        5: send_offset(-1 - longint'($urandom_range(16777214)),
                       $urandom_range(1) ? 1 : -1, z);
        6: send_offset(0, 0, 0);
        default: send_offset(rand_delta(2), rand_delta(2), m);
      endcase
    end
  endtask

  // sender holds off until the pipe is empty, then resumes
  task automatic test_drain_pause();
    test_full_scale(10);
    wait_results_drained();
    test_near_targets(10);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_flow(0, 0);
    test_special_cases();
    test_full_scale(120);
    test_near_targets(150);
    test_axis_targets(60);

    set_flow(50, 0);
    test_full_scale(120);
    test_near_targets(150);
    test_axis_targets(60);

    set_flow(0, 50);
    test_near_targets(150);
    test_full_scale(120);
    test_axis_targets(60);
    test_drain_pause();

    set_flow(14, 14);
    test_axis_targets(60);
    test_full_scale(120);
    test_near_targets(150);

    set_flow(0, 0);
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_spherical.size() != 0) begin
      $error("%0d results never arrived", pending_spherical.size());
      error_count += pending_spherical.size();
    end

    $display("Covered %0d position fixes: special cases, full-scale, near and axis targets,",
             fixes_sent);
    $display("under four flow-control mixes; %0d result transactions checked.",
             results_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
